// ===== sv/distance_vector_route_table_top_assert.svh =====
// Assertion macros shared by the checkers of the distance-vector route table.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dvrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the distance-vector route table.
package dvrt_pkg;

    localparam int DEF_ENTRIES = 8;

    localparam logic [15:0] UNREACH = 16'hFFFF;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_LINK = 2'd1;
    localparam logic [1:0] KIND_ADV  = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_UNCHANGED = 2'd2;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] nh;
        logic [15:0] cost;
        logic [15:0] direct;
    } row_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] dest;
        logic [15:0] nh;
        logic [15:0] cost;
    } res_t;

endpackage

// ===== sv/dvrt_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the distance-vector route table.
interface dvrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [15:0] dest_id;
    logic [15:0] sender_id;
    logic [15:0] cost;

    modport source (output valid, kind, slot, dest_id, sender_id, cost, input ready);
    modport sink (input valid, kind, slot, dest_id, sender_id, cost, output ready);
endinterface

interface dvrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] entry_dest;
    logic [15:0] entry_next_hop;
    logic [15:0] entry_cost;

    modport source (output valid, status, entry_dest, entry_next_hop, entry_cost,
                    input ready);
    modport sink (input valid, status, entry_dest, entry_next_hop, entry_cost,
                  output ready);
endinterface

// ===== sv/dvrt_row_mem.sv =====
`timescale 1ns / 1ps
// Route table row memory with one write port and one registered read port.
module dvrt_row_mem #(
    parameter int ENTRIES = dvrt_pkg::DEF_ENTRIES
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(ENTRIES)-1:0]   waddr,
    input  dvrt_pkg::row_t               wdata,
    input  logic                         re,
    input  logic [$clog2(ENTRIES)-1:0]   raddr,
    output dvrt_pkg::row_t               rdata
);

    dvrt_pkg::row_t row_mem [ENTRIES];
    dvrt_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= row_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/distance_vector_route_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the distance-vector route table.
// The table rows live in one synchronous memory with a single read port, and every
// item is served by a sequencer that reads, modifies and writes rows one at a time.
// A load writes its row, and a read of a loaded slot fetches its row, before the result
// moves to the output register. An advertised distance sweeps all rows once. A link cost
// change sweeps the rows once, then visits each row; every row routed through the changed
// neighbor costs a further sweep. The one read port of the row memory sets the length of
// each of these sequences. A new transaction is accepted as soon as the previous result
// has moved to the output register.
module distance_vector_route_table_top #(
    parameter int ENTRIES = dvrt_pkg::DEF_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
    localparam logic [15:0] UNREACH = dvrt_pkg::UNREACH;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_LC_RD   = 4'd3;
    localparam logic [3:0] S_LC_MOD  = 4'd4;
    localparam logic [3:0] S_LC_WB   = 4'd5;
    localparam logic [3:0] S_RX_RD   = 4'd6;
    localparam logic [3:0] S_RX_MOD  = 4'd7;
    localparam logic [3:0] S_ROW_RD  = 4'd8;
    localparam logic [3:0] S_ROW_OUT = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    localparam logic [1:0] SM_LINK  = 2'd0;
    localparam logic [1:0] SM_RELAX = 2'd1;
    localparam logic [1:0] SM_INNER = 2'd2;

    typedef struct packed {
        logic [15:0]      key;
        logic [15:0]      snd;
        logic [15:0]      c;
        logic [15:0]      skey;
        logic [1:0]       mode;
        logic [IDX_W-1:0] cmp_idx;
        logic             f1;
        logic [IDX_W-1:0] idx1;
        logic [15:0]      dir1;
        logic             f2;
        logic [15:0]      cost2;
        logic [15:0]      prev;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] tgt;
        logic [1:0]       st;
        dvrt_pkg::row_t   row;
        logic [15:0]      upd;
        logic [15:0]      sum;
        dvrt_pkg::res_t   res;
        dvrt_pkg::res_t   out;
    } ctx_t;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               cmp_vld_reg;
    logic               cmp_vld_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    ctx_t               ctx_reg;
    ctx_t               ctx_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    dvrt_pkg::row_t     mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    dvrt_pkg::row_t     mem_rdata;

    logic               slot_oor;
    logic [IDX_W-1:0]   slot_idx;
    logic [16:0]        rx_sum;
    logic [15:0]        rx_sat;
    logic [17:0]        lc_delta;
    logic [15:0]        lc_upd;
    logic [15:0]        lc_dc;
    logic               lc_adv;

    dvrt_row_mem #(
        .ENTRIES (ENTRIES)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_oor = int'(req.slot) >= ENTRIES;
    assign slot_idx = IDX_W'(req.slot);

    assign rx_sum = {1'b0, ctx_reg.cost2} + {1'b0, ctx_reg.c};
    assign rx_sat = rx_sum[16] ? UNREACH : rx_sum[15:0];

    // Path cost shifted by the change of the direct link, clamped to the 16-bit range.
    assign lc_delta = {2'b00, mem_rdata.cost} + {2'b00, ctx_reg.c} - {2'b00, ctx_reg.prev};
    always_comb
    begin
        if (mem_rdata.cost == UNREACH || ctx_reg.c == UNREACH)
        begin
            lc_upd = UNREACH;
        end
        else if (lc_delta[17])
        begin
            lc_upd = '0;
        end
        else if (lc_delta[16])
        begin
            lc_upd = UNREACH;
        end
        else
        begin
            lc_upd = lc_delta[15:0];
        end
    end

    assign lc_dc = ctx_reg.f1 ? ctx_reg.dir1 : UNREACH;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        ctx_next       = ctx_reg;
        mem_we         = 1'b0;
        mem_waddr      = ctx_reg.i;
        mem_wdata      = ctx_reg.row;
        mem_re         = 1'b0;
        mem_raddr      = ctx_reg.tgt;
        lc_adv         = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ctx_next.key  = req.dest_id;
                    ctx_next.snd  = req.sender_id;
                    ctx_next.c    = req.cost;
                    ctx_next.skey = req.dest_id;
                    ctx_next.tgt  = slot_idx;
                    ctx_next.f1   = 1'b0;
                    ctx_next.f2   = 1'b0;
                    cnt_next      = '0;
                    unique case (req.kind)
                        dvrt_pkg::KIND_LOAD:
                        begin
                            if (slot_oor)
                            begin
                                ctx_next.res = '{status: dvrt_pkg::ST_NOT_FOUND,
                                                 dest: '0, nh: '0, cost: '0};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        dvrt_pkg::KIND_LINK:
                        begin
                            ctx_next.mode = SM_LINK;
                            state_next    = S_SCAN;
                        end
                        dvrt_pkg::KIND_ADV:
                        begin
                            ctx_next.mode = SM_RELAX;
                            state_next    = S_SCAN;
                        end
                        dvrt_pkg::KIND_READ:
                        begin
                            if (slot_oor)
                            begin
                                ctx_next.res = '{status: dvrt_pkg::ST_NOT_FOUND,
                                                 dest: '0, nh: '0, cost: '0};
                                state_next = S_EMIT;
                            end
                            else if (!valid_reg[slot_idx])
                            begin
                                ctx_next.res = '{status: dvrt_pkg::ST_DONE,
                                                 dest: '0, nh: '0, cost: '0};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ctx_next.st = dvrt_pkg::ST_DONE;
                                state_next  = S_ROW_RD;
                            end
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                mem_we           = 1'b1;
                mem_waddr        = ctx_reg.tgt;
                mem_wdata.dest   = ctx_reg.key;
                mem_wdata.nh     = (ctx_reg.c != UNREACH) ? ctx_reg.key : UNREACH;
                mem_wdata.cost   = ctx_reg.c;
                mem_wdata.direct = ctx_reg.c;
                valid_next[ctx_reg.tgt] = 1'b1;
                ctx_next.res = '{status: dvrt_pkg::ST_DONE, dest: mem_wdata.dest,
                                 nh: mem_wdata.nh, cost: mem_wdata.cost};
                state_next = S_EMIT;
            end

            S_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    mem_re           = 1'b1;
                    mem_raddr        = cnt_reg[IDX_W-1:0];
                    cmp_vld_next     = 1'b1;
                    ctx_next.cmp_idx = cnt_reg[IDX_W-1:0];
                    cnt_next         = CNT_W'(cnt_reg + 1'b1);
                end
                if (cmp_vld_reg && valid_reg[ctx_reg.cmp_idx])
                begin
                    if (mem_rdata.dest == ctx_reg.skey)
                    begin
                        if (!ctx_reg.f1)
                        begin
                            ctx_next.idx1 = ctx_reg.cmp_idx;
                        end
                        ctx_next.f1   = 1'b1;
                        ctx_next.dir1 = mem_rdata.direct;
                    end
                    if (mem_rdata.dest == ctx_reg.snd)
                    begin
                        ctx_next.f2    = 1'b1;
                        ctx_next.cost2 = mem_rdata.cost;
                    end
                end
                if (cnt_reg == CNT_END && !cmp_vld_reg)
                begin
                    unique case (ctx_reg.mode)
                        SM_LINK:
                        begin
                            if (!ctx_reg.f1)
                            begin
                                ctx_next.res = '{status: dvrt_pkg::ST_NOT_FOUND,
                                                 dest: ctx_reg.key, nh: '0, cost: '0};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ctx_next.prev  = ctx_reg.dir1;
                                ctx_next.first = ctx_reg.idx1;
                                ctx_next.i     = '0;
                                state_next     = S_LC_RD;
                            end
                        end
                        SM_RELAX:
                        begin
                            if (!ctx_reg.f1 || !ctx_reg.f2)
                            begin
                                ctx_next.res = '{status: dvrt_pkg::ST_NOT_FOUND,
                                                 dest: ctx_reg.key, nh: '0, cost: '0};
                                state_next = S_EMIT;
                            end
                            else if (ctx_reg.c == UNREACH)
                            begin
                                ctx_next.tgt = ctx_reg.idx1;
                                ctx_next.st  = dvrt_pkg::ST_UNCHANGED;
                                state_next   = S_ROW_RD;
                            end
                            else
                            begin
                                ctx_next.tgt = ctx_reg.idx1;
                                ctx_next.sum = rx_sat;
                                state_next   = S_RX_RD;
                            end
                        end
                        SM_INNER:
                        begin
                            state_next = S_LC_WB;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LC_RD:
            begin
                if (valid_reg[ctx_reg.i])
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ctx_reg.i;
                    state_next = S_LC_MOD;
                end
                else
                begin
                    lc_adv = 1'b1;
                end
            end

            S_LC_MOD:
            begin
                if (mem_rdata.dest == ctx_reg.key)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = ctx_reg.i;
                    mem_wdata        = mem_rdata;
                    mem_wdata.direct = ctx_reg.c;
                    if (mem_rdata.nh == ctx_reg.key)
                    begin
                        mem_wdata.cost = ctx_reg.c;
                    end
                    else if (mem_rdata.cost > ctx_reg.c)
                    begin
                        mem_wdata.cost = ctx_reg.c;
                        mem_wdata.nh   = ctx_reg.key;
                    end
                    lc_adv = 1'b1;
                end
                else if (mem_rdata.nh == ctx_reg.key)
                begin
                    ctx_next.row  = mem_rdata;
                    ctx_next.upd  = lc_upd;
                    ctx_next.skey = mem_rdata.dest;
                    ctx_next.mode = SM_INNER;
                    ctx_next.f1   = 1'b0;
                    ctx_next.f2   = 1'b0;
                    cnt_next      = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    lc_adv = 1'b1;
                end
            end

            S_LC_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = ctx_reg.i;
                mem_wdata = ctx_reg.row;
                if (lc_dc <= ctx_reg.upd)
                begin
                    mem_wdata.nh   = ctx_reg.row.dest;
                    mem_wdata.cost = lc_dc;
                end
                else
                begin
                    mem_wdata.cost = ctx_reg.upd;
                end
                lc_adv = 1'b1;
            end

            S_RX_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ctx_reg.tgt;
                state_next = S_RX_MOD;
            end

            S_RX_MOD:
            begin
                if (ctx_reg.sum < mem_rdata.cost)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = ctx_reg.tgt;
                    mem_wdata      = mem_rdata;
                    mem_wdata.nh   = ctx_reg.snd;
                    mem_wdata.cost = ctx_reg.sum;
                    ctx_next.res = '{status: dvrt_pkg::ST_DONE, dest: mem_rdata.dest,
                                     nh: ctx_reg.snd, cost: ctx_reg.sum};
                end
                else
                begin
                    ctx_next.res = '{status: dvrt_pkg::ST_UNCHANGED, dest: mem_rdata.dest,
                                     nh: mem_rdata.nh, cost: mem_rdata.cost};
                end
                state_next = S_EMIT;
            end

            S_ROW_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ctx_reg.tgt;
                state_next = S_ROW_OUT;
            end

            S_ROW_OUT:
            begin
                ctx_next.res = '{status: ctx_reg.st, dest: mem_rdata.dest,
                                 nh: mem_rdata.nh, cost: mem_rdata.cost};
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    ctx_next.out   = ctx_reg.res;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // After the last row of a link cost change, the first row of the neighbor is shown.
        if (lc_adv)
        begin
            if (ctx_reg.i == LAST_IDX)
            begin
                ctx_next.tgt = ctx_reg.first;
                ctx_next.st  = dvrt_pkg::ST_DONE;
                state_next   = S_ROW_RD;
            end
            else
            begin
                ctx_next.i = IDX_W'(ctx_reg.i + 1'b1);
                state_next = S_LC_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = ctx_reg.out.status;
    assign rsp.entry_dest     = ctx_reg.out.dest;
    assign rsp.entry_next_hop = ctx_reg.out.nh;
    assign rsp.entry_cost     = ctx_reg.out.cost;

endmodule

// ===== sv/dvrt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the distance-vector route table and its bind.
`include "distance_vector_route_table_top_assert.svh"

module dvrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [15:0] rsp_next_hop,
    input logic [15:0] rsp_cost
);

    // Only one transaction is in work at a time.
    `DVRT_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while another is in work")

    `DVRT_ASSERT_NOW(a_status_code, clk, rst_n, rsp_valid, rsp_status == dvrt_pkg::ST_DONE || rsp_status == dvrt_pkg::ST_NOT_FOUND || rsp_status == dvrt_pkg::ST_UNCHANGED, "undefined status code")

    // A miss carries no route.
    `DVRT_ASSERT_NOW(a_miss_empty, clk, rst_n, rsp_valid && rsp_status == dvrt_pkg::ST_NOT_FOUND, rsp_next_hop == 16'd0 && rsp_cost == 16'd0, "miss result carries a route")

    `DVRT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_next_hop) && $stable(rsp_cost), "stalled response changed")

endmodule

bind distance_vector_route_table_top dvrt_checker u_dvrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_next_hop (rsp.entry_next_hop),
    .rsp_cost     (rsp.entry_cost)
);

// ===== tb/tb_distance_vector_route_table_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the distance-vector route table with a built-in route predictor.
module tb_distance_vector_route_table_top;
    import dvrt_pkg::*;

    localparam int ENTRIES = DEF_ENTRIES;
    localparam int TOTAL_ITEMS = 1350;
    localparam int POOL_SIZE = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [15:0] dest_id;
        logic [15:0] sender_id;
        logic [15:0] cost;
    } route_req_t;

    logic clk = 1'b0;
    logic rst_n;

    dvrt_req_if req_ch ();
    dvrt_rsp_if rsp_ch ();

    distance_vector_route_table_top #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [15:0] tbl_dest [ENTRIES];
    logic [15:0] tbl_next_hop [ENTRIES];
    logic [15:0] tbl_cost [ENTRIES];
    logic [15:0] tbl_direct [ENTRIES];
    bit          tbl_valid [ENTRIES];

    route_req_t pending_reqs [$];
    res_t       expected_routes [$];
    route_req_t cur_req;

    logic [15:0] id_pool [POOL_SIZE];
    bit          slot_loaded [ENTRIES];
    int          queued_items = 0;

    int mismatch_count = 0;
    int kind_count [4] = '{default: 0};
    int status_count [4] = '{default: 0};
    int burst_left = 0;
    int gap_left = 0;
    int rcv_cycle = 0;
    int rcv_mode = 0;
    int idle_cycles = 0;

    function automatic int find_row(logic [15:0] id, bit want_last);
        int found;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_dest[i] == id && (want_last || found < 0))
            begin
                found = i;
            end
        end
        return found;
    endfunction

    function automatic res_t row_result(logic [1:0] status, int idx);
        res_t r;
        r.status = status;
        r.dest = tbl_dest[idx];
        r.nh = tbl_next_hop[idx];
        r.cost = tbl_cost[idx];
        return r;
    endfunction

    function automatic res_t route_table_predict(route_req_t rq);
        res_t        miss;
        int          last;
        int          s;
        int          j;
        int          d;
        int          upd;
        int          old_cost;
        logic [15:0] prev;
        logic [15:0] dc;
        logic [16:0] sum;
        miss = '{status: ST_NOT_FOUND, dest: rq.dest_id, nh: 16'h0, cost: 16'h0};
        case (rq.kind)
            KIND_LINK:
            begin
                last = find_row(rq.dest_id, 1'b1);
                if (last < 0)
                begin
                    return miss;
                end
                prev = tbl_direct[last];
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_dest[i] == rq.dest_id)
                    begin
                        tbl_direct[i] = rq.cost;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!tbl_valid[i])
                    begin
                        continue;
                    end
                    if (tbl_dest[i] == rq.dest_id && tbl_next_hop[i] == rq.dest_id)
                    begin
                        tbl_cost[i] = rq.cost;
                    end
                    else if (tbl_dest[i] == rq.dest_id && tbl_cost[i] > rq.cost)
                    begin
                        tbl_cost[i] = rq.cost;
                        tbl_next_hop[i] = rq.dest_id;
                    end
                    else if (tbl_next_hop[i] == rq.dest_id)
                    begin
                        if (tbl_cost[i] == UNREACH || rq.cost == UNREACH)
                        begin
                            upd = UNREACH;
                        end
                        else
                        begin
                            old_cost = tbl_cost[i];
                            upd = old_cost - int'({16'h0, prev}) + int'({16'h0, rq.cost});
                            if (upd < 0)
                            begin
                                upd = 0;
                            end
                            if (upd > int'({16'h0, UNREACH}))
                            begin
                                upd = UNREACH;
                            end
                        end
                        d = find_row(tbl_dest[i], 1'b1);
                        dc = (d >= 0) ? tbl_direct[d] : UNREACH;
                        if (int'({16'h0, dc}) <= upd)
                        begin
                            tbl_next_hop[i] = tbl_dest[i];
                            tbl_cost[i] = dc;
                        end
                        else
                        begin
                            tbl_cost[i] = 16'(upd);
                        end
                    end
                end
                return row_result(ST_DONE, find_row(rq.dest_id, 1'b0));
            end
            KIND_ADV:
            begin
                s = find_row(rq.sender_id, 1'b1);
                j = find_row(rq.dest_id, 1'b0);
                if (s < 0 || j < 0)
                begin
                    return miss;
                end
                if (rq.cost == UNREACH)
                begin
                    return row_result(ST_UNCHANGED, j);
                end
                sum = {1'b0, tbl_cost[s]} + {1'b0, rq.cost};
                if (sum > {1'b0, UNREACH})
                begin
                    sum = {1'b0, UNREACH};
                end
                if (sum < {1'b0, tbl_cost[j]})
                begin
                    tbl_next_hop[j] = rq.sender_id;
                    tbl_cost[j] = sum[15:0];
                    return row_result(ST_DONE, j);
                end
                return row_result(ST_UNCHANGED, j);
            end
            default:
            begin
                if (int'(rq.slot) >= ENTRIES)
                begin
                    return '{status: ST_NOT_FOUND, dest: 16'h0, nh: 16'h0, cost: 16'h0};
                end
                if (rq.kind == KIND_LOAD)
                begin
                    tbl_dest[rq.slot] = rq.dest_id;
                    tbl_cost[rq.slot] = rq.cost;
                    tbl_direct[rq.slot] = rq.cost;
                    tbl_next_hop[rq.slot] = (rq.cost < UNREACH) ? rq.dest_id : UNREACH;
                    tbl_valid[rq.slot] = 1'b1;
                end
                return row_result(ST_DONE, int'(rq.slot));
            end
        endcase
    endfunction

    function automatic void enqueue_request(logic [1:0] kind, logic [2:0] slot,
                                            logic [15:0] dest_id, logic [15:0] sender_id,
                                            logic [15:0] cost);
        pending_reqs.push_back('{kind: kind, slot: slot, dest_id: dest_id,
                                 sender_id: sender_id, cost: cost});
        if (kind == KIND_LOAD)
        begin
            slot_loaded[slot] = 1'b1;
        end
        queued_items++;
    endfunction

    function automatic logic [15:0] rand_cost();
        case ($urandom_range(0, 9))
            0: return UNREACH;
            1: return 16'h0;
            2: return UNREACH - 16'd1;
            3: return 16'($urandom);
            4: return 16'($urandom_range(32768, 65534));
            default: return 16'($urandom_range(1, 60));
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 19) < 17)
        begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return 16'($urandom);
    endfunction

    function automatic logic [2:0] pick_loaded_slot();
        logic [2:0] s;
        do
        begin
            s = 3'($urandom_range(0, ENTRIES - 1));
        end
        while (!slot_loaded[s]);
        return s;
    endfunction

    always @(posedge clk)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_routes.push_back(route_table_predict(cur_req));
                kind_count[cur_req.kind]++;
                next_valid = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = 0;
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                           : $urandom_range(0, 3);
                end
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() > 0)
                begin
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                    end
                    cur_req = pending_reqs.pop_front();
                    req_ch.kind <= cur_req.kind;
                    req_ch.slot <= cur_req.slot;
                    req_ch.dest_id <= cur_req.dest_id;
                    req_ch.sender_id <= cur_req.sender_id;
                    req_ch.cost <= cur_req.cost;
                    next_valid = 1'b1;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        logic next_ready;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Unexpected result: status %0d dest %h next hop %h cost %0d",
                                 rsp_ch.status, rsp_ch.entry_dest, rsp_ch.entry_next_hop,
                                 rsp_ch.entry_cost);
                    end
                end
                else
                begin
                    want = expected_routes.pop_front();
                    status_count[want.status]++;
                    if (rsp_ch.status !== want.status || rsp_ch.entry_dest !== want.dest ||
                        rsp_ch.entry_next_hop !== want.nh || rsp_ch.entry_cost !== want.cost)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Mismatch: expected status %0d dest %h next hop %h cost %0d",
                                     want.status, want.dest, want.nh, want.cost);
                            $display("          got      status %0d dest %h next hop %h cost %0d",
                                     rsp_ch.status, rsp_ch.entry_dest, rsp_ch.entry_next_hop,
                                     rsp_ch.entry_cost);
                        end
                    end
                end
            end
            rcv_cycle++;
            if (rcv_cycle % 50 == 0)
            begin
                rcv_mode = $urandom_range(0, 3);
            end
            case (rcv_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (rcv_cycle % 4 == 0);
                default: next_ready = (rcv_cycle % 16 >= 10);
            endcase
            rsp_ch.ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int  ops;
        int  pick;
        logic [1:0] noise_kind;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOAD;
        req_ch.slot = 3'd0;
        req_ch.dest_id = 16'h0;
        req_ch.sender_id = 16'h0;
        req_ch.cost = 16'h0;
        rsp_ch.ready = 1'b0;

        enqueue_request(KIND_LOAD, 3'd0, 16'h0001, 16'h0, 16'd10);
        enqueue_request(KIND_LOAD, 3'd1, 16'h0002, 16'h0, 16'd3);
        enqueue_request(KIND_LOAD, 3'd2, 16'h0003, 16'h0, UNREACH);
        enqueue_request(KIND_LOAD, 3'd3, 16'hFFFF, 16'h0, 16'd0);
        enqueue_request(KIND_LOAD, 3'd7, 16'h0000, 16'h0, UNREACH - 16'd1);
        enqueue_request(KIND_READ, 3'd3, 16'h0, 16'h0, 16'h0);
        enqueue_request(KIND_READ, 3'd7, 16'h0, 16'h0, 16'h0);
        enqueue_request(KIND_ADV, 3'd0, 16'h0003, 16'h0002, 16'd4);
        enqueue_request(KIND_ADV, 3'd0, 16'h0003, 16'h0002, 16'd10);
        enqueue_request(KIND_ADV, 3'd0, 16'h0001, 16'h0002, UNREACH);
        enqueue_request(KIND_LOAD, 3'd4, 16'h0004, 16'h0, UNREACH);
        enqueue_request(KIND_ADV, 3'd0, 16'h0004, 16'h0000, 16'd2);
        enqueue_request(KIND_ADV, 3'd0, 16'h0001, 16'h1234, 16'd1);
        enqueue_request(KIND_ADV, 3'd0, 16'h4321, 16'h0001, 16'd1);
        enqueue_request(KIND_LINK, 3'd0, 16'h5555, 16'h0, 16'd7);
        enqueue_request(KIND_ADV, 3'd0, 16'h0001, 16'h0002, 16'd2);
        enqueue_request(KIND_LOAD, 3'd5, 16'h0002, 16'h0, 16'd40);
        enqueue_request(KIND_LINK, 3'd0, 16'h0002, 16'h0, 16'd1);
        enqueue_request(KIND_LOAD, 3'd6, 16'h0006, 16'h0, UNREACH);
        enqueue_request(KIND_ADV, 3'd0, 16'h0006, 16'h0000, 16'd0);
        enqueue_request(KIND_LOAD, 3'd7, 16'h0000, 16'h0, 16'd1);
        enqueue_request(KIND_LINK, 3'd0, 16'h0000, 16'h0, 16'd100);
        enqueue_request(KIND_LINK, 3'd0, 16'h0002, 16'h0, UNREACH);
        enqueue_request(KIND_READ, 3'd0, 16'h0, 16'h0, 16'h0);
        enqueue_request(KIND_READ, 3'd2, 16'h0, 16'h0, 16'h0);

        while (queued_items < TOTAL_ITEMS)
        begin
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                case ($urandom_range(0, 9))
                    0: id_pool[k] = 16'h0000;
                    1: id_pool[k] = 16'hFFFF;
                    default: id_pool[k] = 16'($urandom);
                endcase
            end
            if ($urandom_range(0, 2) == 0)
            begin
                for (int k = 0; k < ENTRIES; k++)
                begin
                    enqueue_request(KIND_LOAD, 3'(k), pick_id(), 16'($urandom), rand_cost());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    enqueue_request(KIND_LOAD, 3'($urandom), pick_id(), 16'($urandom),
                                    rand_cost());
                end
            end
            ops = $urandom_range(15, 60);
            repeat (ops)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    enqueue_request(KIND_LINK, 3'($urandom), pick_id(), 16'($urandom),
                                    rand_cost());
                end
                else if (pick < 70)
                begin
                    enqueue_request(KIND_ADV, 3'($urandom), pick_id(), pick_id(), rand_cost());
                end
                else if (pick < 82)
                begin
                    enqueue_request(KIND_READ, pick_loaded_slot(), 16'($urandom),
                                    16'($urandom), 16'($urandom));
                end
                else if (pick < 95)
                begin
                    enqueue_request(KIND_LOAD, 3'($urandom), pick_id(), 16'($urandom),
                                    rand_cost());
                end
                else
                begin
                    noise_kind = 2'($urandom);
                    enqueue_request(noise_kind,
                                    (noise_kind == KIND_READ) ? pick_loaded_slot()
                                                              : 3'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom));
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (pending_reqs.size() != 0 || req_ch.valid || expected_routes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d loads, %0d link changes, %0d advertised distances, %0d reads.",
                 queued_items, kind_count[KIND_LOAD], kind_count[KIND_LINK],
                 kind_count[KIND_ADV], kind_count[KIND_READ]);
        $display("Answers seen: %0d done, %0d not found, %0d unchanged; %0d mismatches.",
                 status_count[ST_DONE], status_count[ST_NOT_FOUND],
                 status_count[ST_UNCHANGED], mismatch_count);
        if (mismatch_count == 0 && expected_routes.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dvrt_pkg.sv
sv/dvrt_if.sv
sv/dvrt_row_mem.sv
sv/distance_vector_route_table_top.sv
sv/dvrt_checker.sv
tb/tb_distance_vector_route_table_top.sv
